@@ rtl/core/bbip_pkg.sv @@
// bbip_pkg: shared types and constants for the box boundary impulse projection block.
// No dependencies; used by the channel interfaces, bbip_axis and the top level.
package bbip_pkg;

   localparam int NUM_STAGES = 6;
   localparam int TAG_W      = 16;
   localparam int COORD_W    = 32;
   localparam int SCALE_W    = 32;
   localparam int DIAM_W     = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SIM_SCALE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DIAMETER  = 3'd7;

   localparam logic signed [COORD_W-1:0] BOX_MIN_RST = 32'sd0;
   localparam logic signed [COORD_W-1:0] BOX_MAX_RST = 32'sd4194304;
   localparam logic [SCALE_W-1:0]        SCALE_RST   = 32'd67109;
   localparam logic [DIAM_W-1:0]         DIAM_RST    = 31'd0;

   // 0.005 in Q0.24
   localparam logic [16:0] PUSH_FRAC_Q24 = 17'd83886;

   typedef logic [NUM_STAGES-1:0] stage_en_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] lo;
      logic signed [COORD_W-1:0] hi;
   } bounds_type;

endpackage

@@ rtl/core/bbip_if.sv @@
// Valid/ready channel interfaces of the box boundary impulse projection block.
// Depends on bbip_pkg for field widths.
interface bbip_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [bbip_pkg::TAG_W-1:0]           particle_tag;
   logic signed [bbip_pkg::COORD_W-1:0]  pos_x;
   logic signed [bbip_pkg::COORD_W-1:0]  pos_y;
   logic signed [bbip_pkg::COORD_W-1:0]  pos_z;
   logic signed [bbip_pkg::COORD_W-1:0]  vel_x;
   logic signed [bbip_pkg::COORD_W-1:0]  vel_y;
   logic signed [bbip_pkg::COORD_W-1:0]  vel_z;

   modport source (output valid, particle_tag, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   input ready);
   modport sink   (input valid, particle_tag, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   output ready);
endinterface

interface bbip_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [bbip_pkg::TAG_W-1:0]           particle_tag_out;
   logic signed [bbip_pkg::COORD_W-1:0]  new_pos_x;
   logic signed [bbip_pkg::COORD_W-1:0]  new_pos_y;
   logic signed [bbip_pkg::COORD_W-1:0]  new_pos_z;
   logic signed [bbip_pkg::COORD_W-1:0]  new_vel_x;
   logic signed [bbip_pkg::COORD_W-1:0]  new_vel_y;
   logic signed [bbip_pkg::COORD_W-1:0]  new_vel_z;
   logic signed [bbip_pkg::COORD_W-1:0]  eval_vel_x;
   logic signed [bbip_pkg::COORD_W-1:0]  eval_vel_y;
   logic signed [bbip_pkg::COORD_W-1:0]  eval_vel_z;

   modport source (output valid, particle_tag_out, new_pos_x, new_pos_y, new_pos_z,
                   new_vel_x, new_vel_y, new_vel_z, eval_vel_x, eval_vel_y, eval_vel_z,
                   input ready);
   modport sink   (input valid, particle_tag_out, new_pos_x, new_pos_y, new_pos_z,
                   new_vel_x, new_vel_y, new_vel_z, eval_vel_x, eval_vel_y, eval_vel_z,
                   output ready);
endinterface

interface bbip_csr_if;
   logic                               valid;
   logic                               ready;
   logic [bbip_pkg::CSR_IDX_W-1:0]     index;
   logic [bbip_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/box_boundary_impulse_projection.sv @@
// Box boundary impulse projection: six-stage pipeline, one particle per cycle
// while the output is not stalled. A result passes through stages 0 to 5 in
// order and is offered on the response channel from the last stage.
// Throughput: one transfer per cycle; each stage advances when it is empty or the
// next stage advances, so a stalled output only holds back what sits behind it.
// Reset clears all stage valid bits and loads the box/scale/diameter defaults.
module box_boundary_impulse_projection (
   input  logic        clock,
   input  logic        reset,
   bbip_req_if.sink    req_chan,
   bbip_rsp_if.source  rsp_chan,
   bbip_csr_if.sink    csr_chan
);

   localparam int NS = bbip_pkg::NUM_STAGES;

   logic signed [31:0] box_min_x_ff, box_min_y_ff, box_min_z_ff;
   logic signed [31:0] box_max_x_ff, box_max_y_ff, box_max_z_ff;
   logic [bbip_pkg::SCALE_W-1:0] scale_ff;
   logic [bbip_pkg::DIAM_W-1:0]  diam_ff;

   logic [NS-1:0]              vld_ff;
   bbip_pkg::stage_en_type     adv;
   logic [bbip_pkg::TAG_W-1:0] tag_ff [NS];
   logic                       csr_wr;

   // advance chain from the output back to the input
   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || rsp_chan.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_chan.ready = adv[0];
   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff <= bbip_pkg::BOX_MIN_RST;
         box_min_y_ff <= bbip_pkg::BOX_MIN_RST;
         box_min_z_ff <= bbip_pkg::BOX_MIN_RST;
         box_max_x_ff <= bbip_pkg::BOX_MAX_RST;
         box_max_y_ff <= bbip_pkg::BOX_MAX_RST;
         box_max_z_ff <= bbip_pkg::BOX_MAX_RST;
         scale_ff     <= bbip_pkg::SCALE_RST;
         diam_ff      <= bbip_pkg::DIAM_RST;
      end else if (csr_wr) begin
         case (csr_chan.index)
            bbip_pkg::REG_BOX_MIN_X: box_min_x_ff <= csr_chan.data;
            bbip_pkg::REG_BOX_MIN_Y: box_min_y_ff <= csr_chan.data;
            bbip_pkg::REG_BOX_MIN_Z: box_min_z_ff <= csr_chan.data;
            bbip_pkg::REG_BOX_MAX_X: box_max_x_ff <= csr_chan.data;
            bbip_pkg::REG_BOX_MAX_Y: box_max_y_ff <= csr_chan.data;
            bbip_pkg::REG_BOX_MAX_Z: box_max_z_ff <= csr_chan.data;
            bbip_pkg::REG_SIM_SCALE: scale_ff     <= csr_chan.data;
            bbip_pkg::REG_DIAMETER:  diam_ff      <= csr_chan.data[bbip_pkg::DIAM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         tag_ff[0] <= req_chan.particle_tag;
      end
      for (int i = 1; i < NS; i++) begin
         if (adv[i]) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   bbip_axis u_axis_x (
      .clock    (clock),
      .stage_en (adv),
      .bounds   ({box_min_x_ff, box_max_x_ff}),
      .scale    (scale_ff),
      .diam     (diam_ff),
      .pos_in   (req_chan.pos_x),
      .vel_in   (req_chan.vel_x),
      .new_pos  (rsp_chan.new_pos_x),
      .new_vel  (rsp_chan.new_vel_x),
      .eval_vel (rsp_chan.eval_vel_x)
   );

   bbip_axis u_axis_y (
      .clock    (clock),
      .stage_en (adv),
      .bounds   ({box_min_y_ff, box_max_y_ff}),
      .scale    (scale_ff),
      .diam     (diam_ff),
      .pos_in   (req_chan.pos_y),
      .vel_in   (req_chan.vel_y),
      .new_pos  (rsp_chan.new_pos_y),
      .new_vel  (rsp_chan.new_vel_y),
      .eval_vel (rsp_chan.eval_vel_y)
   );

   bbip_axis u_axis_z (
      .clock    (clock),
      .stage_en (adv),
      .bounds   ({box_min_z_ff, box_max_z_ff}),
      .scale    (scale_ff),
      .diam     (diam_ff),
      .pos_in   (req_chan.pos_z),
      .vel_in   (req_chan.vel_z),
      .new_pos  (rsp_chan.new_pos_z),
      .new_vel  (rsp_chan.new_vel_z),
      .eval_vel (rsp_chan.eval_vel_z)
   );

   assign rsp_chan.valid            = vld_ff[NS-1];
   assign rsp_chan.particle_tag_out = tag_ff[NS-1];

   // a full pipeline with a stalled output must refuse new input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input accepted while pipeline full and stalled");

   // an accepted transfer lands in stage 0
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[0])
      else $error("accepted transfer lost at stage 0");

   // a waiting result stays in the last stage
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-1] && !rsp_chan.ready |=> vld_ff[NS-1])
      else $error("pending result dropped");

   // the next-to-last stage, holding an item that cannot move, keeps it
   a_mid_held: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-2] && !adv[NS-1] |=> vld_ff[NS-2])
      else $error("stalled item lost in pipeline");

endmodule

@@ rtl/core/bbip_axis.sv @@
// bbip_axis: six-stage datapath for one axis: wall distances, penetration,
// push-out, velocity clamp and mean velocity. Depends on bbip_pkg.
module bbip_axis (
   input  logic                                clock,
   input  bbip_pkg::stage_en_type              stage_en,
   input  bbip_pkg::bounds_type                bounds,
   input  logic [bbip_pkg::SCALE_W-1:0]        scale,
   input  logic [bbip_pkg::DIAM_W-1:0]         diam,
   input  logic signed [bbip_pkg::COORD_W-1:0] pos_in,
   input  logic signed [bbip_pkg::COORD_W-1:0] vel_in,
   output logic signed [bbip_pkg::COORD_W-1:0] new_pos,
   output logic signed [bbip_pkg::COORD_W-1:0] new_vel,
   output logic signed [bbip_pkg::COORD_W-1:0] eval_vel
);

   localparam logic [58:0] PUSH_Q24_EXT = {42'd0, bbip_pkg::PUSH_FRAC_Q24};

   // position and velocity travel alongside stages 0..4
   logic signed [31:0] pos_ff [5];
   logic signed [31:0] vel_ff [5];

   // stage 0: raw distances to both walls
   logic signed [32:0] dlo_ff, dhi_ff;
   // stage 1: scale split into two 16-bit halves
   logic signed [49:0] plo_l_ff, plo_h_ff, phi_l_ff, phi_h_ff;
   // stage 2: distances at simulation scale, floor
   logic signed [65:0] sum_lo, sum_hi;
   logic signed [40:0] slo_ff, shi_ff;
   // stage 3: negated distance, diameter - scaled
   logic signed [42:0] nlo_ff, nhi_ff;
   // stage 4: push amounts and clamped velocity
   logic               pen_lo, pen_hi;
   logic [41:0]        mag_lo, mag_hi;
   logic [58:0]        prod_lo, prod_hi;
   logic [34:0]        push_lo_ff, push_hi_ff;
   logic signed [31:0] nv_in, nv_ff;
   // stage 5: result registers
   logic signed [36:0] np_sum;
   logic signed [32:0] ev_sum;
   logic signed [31:0] np_in, new_pos_ff, new_vel_ff, eval_vel_ff;

   assign sum_lo = {{16{plo_l_ff[49]}}, plo_l_ff} + {plo_h_ff, 16'b0};
   assign sum_hi = {{16{phi_l_ff[49]}}, phi_l_ff} + {phi_h_ff, 16'b0};

   assign pen_lo  = nlo_ff > 43'sd1;
   assign pen_hi  = nhi_ff > 43'sd1;
   assign mag_lo  = pen_lo ? nlo_ff[41:0] : 42'd0;
   assign mag_hi  = pen_hi ? nhi_ff[41:0] : 42'd0;
   assign prod_lo = mag_lo * PUSH_Q24_EXT;
   assign prod_hi = mag_hi * PUSH_Q24_EXT;

   always_comb begin
      nv_in = vel_ff[3];
      if (pen_lo && vel_ff[3][31]) begin
         nv_in = 32'sd0;
      end
      if (pen_hi && !vel_ff[3][31] && vel_ff[3] != 32'sd0) begin
         nv_in = 32'sd0;
      end
   end

   assign np_sum = {{5{pos_ff[4][31]}}, pos_ff[4]} + $signed({2'b0, push_lo_ff})
                   - $signed({2'b0, push_hi_ff});
   assign ev_sum = {vel_ff[4][31], vel_ff[4]} + {nv_ff[31], nv_ff};

   // saturate to signed 32 bits
   always_comb begin
      if (np_sum[36:31] == 6'b000000 || np_sum[36:31] == 6'b111111) begin
         np_in = np_sum[31:0];
      end else if (np_sum[36]) begin
         np_in = 32'sh8000_0000;
      end else begin
         np_in = 32'sh7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pos_ff[0] <= pos_in;
         vel_ff[0] <= vel_in;
         dlo_ff    <= {pos_in[31], pos_in} - {bounds.lo[31], bounds.lo};
         dhi_ff    <= {bounds.hi[31], bounds.hi} - {pos_in[31], pos_in};
      end
      if (stage_en[1]) begin
         pos_ff[1] <= pos_ff[0];
         vel_ff[1] <= vel_ff[0];
         plo_l_ff  <= dlo_ff * $signed({1'b0, scale[15:0]});
         plo_h_ff  <= dlo_ff * $signed({1'b0, scale[31:16]});
         phi_l_ff  <= dhi_ff * $signed({1'b0, scale[15:0]});
         phi_h_ff  <= dhi_ff * $signed({1'b0, scale[31:16]});
      end
      if (stage_en[2]) begin
         pos_ff[2] <= pos_ff[1];
         vel_ff[2] <= vel_ff[1];
         slo_ff    <= sum_lo[64:24];
         shi_ff    <= sum_hi[64:24];
      end
      if (stage_en[3]) begin
         pos_ff[3] <= pos_ff[2];
         vel_ff[3] <= vel_ff[2];
         nlo_ff    <= $signed({12'd0, diam}) - {{2{slo_ff[40]}}, slo_ff};
         nhi_ff    <= $signed({12'd0, diam}) - {{2{shi_ff[40]}}, shi_ff};
      end
      if (stage_en[4]) begin
         pos_ff[4]  <= pos_ff[3];
         vel_ff[4]  <= vel_ff[3];
         push_lo_ff <= prod_lo[58:24];
         push_hi_ff <= prod_hi[58:24];
         nv_ff      <= nv_in;
      end
      if (stage_en[5]) begin
         new_pos_ff  <= np_in;
         new_vel_ff  <= nv_ff;
         eval_vel_ff <= ev_sum[32:1];
      end
   end

   assign new_pos  = new_pos_ff;
   assign new_vel  = new_vel_ff;
   assign eval_vel = eval_vel_ff;

endmodule
